>>> rtl/saturating_count_singleton_filter_macros.svh
// ============================================================================
// Assertion macros for the saturating count singleton filter
// Short forms for clocked implications with an active-low reset.
// ============================================================================
`ifndef SATURATING_COUNT_SINGLETON_FILTER_MACROS_SVH
`define SATURATING_COUNT_SINGLETON_FILTER_MACROS_SVH

// Same-cycle implication.
`define SCSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define SCSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/scsf_pkg.sv
// ============================================================================
// scsf_pkg
// Shared types and constants of the saturating count singleton filter.
// ============================================================================
`timescale 1ns / 1ps

package scsf_pkg;

    localparam int LOG2_BINS_DEFAULT  = 16;
    localparam int MAX_IDEALS_DEFAULT = 16;

    localparam int COUNT_W = 8;
    localparam int TALLY_W = 17;
    localparam int CFG_W   = 5;
    localparam int BIN_W   = 16;
    localparam int OP_W    = 2;

    localparam logic [COUNT_W-1:0] SAT_MAX   = 8'hFF;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 17'h1FFFF;
    localparam logic [CFG_W-1:0]   LOG2_BINS_IN_USE_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_COUNT  = 2'd1,
        OP_CHECK  = 2'd2,
        OP_CENSUS = 2'd3
    } op_t;

    // Commands from the sequencer to the relation buffer.
    typedef struct packed {
        logic push;
        logic mark_singleton;
        logic restart;
    } rb_ctrl_t;

    // Flags the relation buffer keeps for the relation in progress.
    typedef struct packed {
        logic singleton_seen;
        logic overflow_seen;
    } rb_status_t;

endpackage

>>> rtl/saturating_count_singleton_filter.sv
// ============================================================================
// saturating_count_singleton_filter
// Table of saturating 8-bit bin counters in a RAM, with count, check,
// clear and census commands and a buffer for the bins of one relation.
// ============================================================================
//
//  Channel   Signals                                        Direction
//  --------  ---------------------------------------------  ---------
//  command   start, busy, op, bin, has_ideal,               in
//            last_of_relation
//  result    done, verdict_valid, singleton, tally,         out
//            overflow
//  config    cfg_we, cfg_wdata (log2_bins_in_use)           in
//
// A command transfer takes place at a clock edge with start high and busy
// low. For count and check commands the accepting edge reads the counter
// RAM and the next edge writes it back. A check that closes a singleton
// relation then decrements each buffered bin, each with its own read and
// write of the RAM port pair. Clear and census walk the low 2^lg entries
// of the RAM one entry per cycle, where lg is log2_bins_in_use limited to
// LOG2_BINS; census passes through a tail state before its result.
// After reset the block zeroes the whole RAM with busy held high;
// configuration writes are taken during that pass.
// Every command yields exactly one result transfer, shown for one cycle
// with done high; the receiver cannot stall it.
// ============================================================================
`timescale 1ns / 1ps

module saturating_count_singleton_filter #(
    parameter int LOG2_BINS  = scsf_pkg::LOG2_BINS_DEFAULT,
    parameter int MAX_IDEALS = scsf_pkg::MAX_IDEALS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [scsf_pkg::OP_W-1:0]     op,
    input  logic [scsf_pkg::BIN_W-1:0]    bin,
    input  logic                          has_ideal,
    input  logic                          last_of_relation,
    // Result channel
    output logic                          done,
    output logic                          verdict_valid,
    output logic                          singleton,
    output logic [scsf_pkg::TALLY_W-1:0]  tally,
    output logic                          overflow,
    // Configuration
    input  logic                          cfg_we,
    input  logic [scsf_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int ADDR_W  = LOG2_BINS;
    localparam int COUNT_W = scsf_pkg::COUNT_W;
    localparam int TALLY_W = scsf_pkg::TALLY_W;
    localparam int CFG_W   = scsf_pkg::CFG_W;
    localparam int IDX_W   = $clog2(MAX_IDEALS);
    localparam int FILL_W  = $clog2(MAX_IDEALS + 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_CNT,
        ST_CHK,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_CEN_RD,
        ST_CEN_TAIL
    } state_t;

    state_t               state_reg,  state_next;
    logic [ADDR_W-1:0]    addr_reg,   addr_next;
    logic                 has_reg,    has_next;
    logic                 last_reg,   last_next;
    logic [FILL_W-1:0]    idx_reg,    idx_next;
    logic [TALLY_W-1:0]   filled_reg, filled_next;
    logic [TALLY_W-1:0]   census_reg, census_next;
    logic                 rvalid_reg, rvalid_next;
    logic [CFG_W-1:0]     lg_reg,     lg_next;
    logic                 done_reg,   done_next;
    logic                 verdict_valid_reg, verdict_valid_next;
    logic                 singleton_reg,     singleton_next;
    logic [TALLY_W-1:0]   tally_reg,  tally_next;
    logic                 overflow_reg, overflow_next;

    // Counter RAM ports
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [COUNT_W-1:0]   ram_rdata;

    // Relation buffer ports
    scsf_pkg::rb_ctrl_t   rb_ctrl;
    logic [IDX_W-1:0]     rb_rd_idx;
    logic [ADDR_W-1:0]    rb_rd_data;
    logic [FILL_W-1:0]    rb_fill;
    scsf_pkg::rb_status_t rb_status;

    logic [CFG_W-1:0]     lg_eff;
    logic [ADDR_W-1:0]    bin_mask;
    logic [ADDR_W-1:0]    in_bin;
    logic                 accept;
    logic                 chk_hit;
    logic                 chk_single;
    logic                 cen_inc;
    logic [FILL_W-1:0]    idx_inc;

    // The bins in use are the low 2^lg entries; indexes wrap into them.
    assign lg_eff   = (lg_reg > CFG_W'(LOG2_BINS)) ? CFG_W'(LOG2_BINS) : lg_reg;
    assign bin_mask = ~({ADDR_W{1'b1}} << lg_eff);
    assign in_bin   = ADDR_W'(bin) & bin_mask;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign chk_hit    = has_reg && (ram_rdata <= COUNT_W'(1));
    assign chk_single = rb_status.singleton_seen || chk_hit;
    assign cen_inc    = rvalid_reg && (ram_rdata != '0) && (census_reg != scsf_pkg::TALLY_MAX);
    assign idx_inc    = idx_reg + FILL_W'(1);

    assign lg_next = cfg_we ? cfg_wdata : lg_reg;

    always_comb
    begin
        state_next         = state_reg;
        addr_next          = addr_reg;
        has_next           = has_reg;
        last_next          = last_reg;
        idx_next           = idx_reg;
        filled_next        = filled_reg;
        census_next        = census_reg;
        rvalid_next        = rvalid_reg;
        done_next          = 1'b0;
        verdict_valid_next = verdict_valid_reg;
        singleton_next     = singleton_reg;
        tally_next         = tally_reg;
        overflow_next      = overflow_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = addr_reg;

        rb_ctrl   = '0;
        rb_rd_idx = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_INIT:
            begin
                // Power-up pass over the whole RAM.
                ram_we = 1'b1;
                if (addr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    has_next  = has_ideal;
                    last_next = last_of_relation;
                    case (op)
                        scsf_pkg::OP_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = ST_CLR;
                        end
                        scsf_pkg::OP_COUNT:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = in_bin;
                            addr_next  = in_bin;
                            state_next = ST_CNT;
                        end
                        scsf_pkg::OP_CHECK:
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = in_bin;
                            addr_next    = in_bin;
                            rb_ctrl.push = has_ideal;
                            state_next   = ST_CHK;
                        end
                        default:
                        begin
                            addr_next   = '0;
                            census_next = '0;
                            rvalid_next = 1'b0;
                            state_next  = ST_CEN_RD;
                        end
                    endcase
                end
            end

            ST_CLR:
            begin
                ram_we = 1'b1;
                if (addr_reg == bin_mask)
                begin
                    filled_next        = '0;
                    rb_ctrl.restart    = 1'b1;
                    done_next          = 1'b1;
                    verdict_valid_next = 1'b0;
                    singleton_next     = 1'b0;
                    tally_next         = '0;
                    overflow_next      = 1'b0;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            ST_CNT:
            begin
                if (has_reg)
                begin
                    if ((ram_rdata == '0) && (filled_reg != scsf_pkg::TALLY_MAX))
                    begin
                        filled_next = filled_reg + TALLY_W'(1);
                    end
                    if (ram_rdata != scsf_pkg::SAT_MAX)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata + COUNT_W'(1);
                    end
                end
                done_next          = 1'b1;
                verdict_valid_next = 1'b0;
                singleton_next     = 1'b0;
                tally_next         = filled_next;
                overflow_next      = 1'b0;
                state_next         = ST_IDLE;
            end

            ST_CHK:
            begin
                rb_ctrl.mark_singleton = chk_hit;
                rb_rd_idx              = '0;
                idx_next               = '0;
                if (last_reg && chk_single && (rb_fill != '0))
                begin
                    state_next = ST_DEC_RD;
                end
                else
                begin
                    done_next          = 1'b1;
                    verdict_valid_next = last_reg;
                    singleton_next     = last_reg && chk_single;
                    tally_next         = '0;
                    overflow_next      = last_reg && rb_status.overflow_seen;
                    rb_ctrl.restart    = last_reg;
                    state_next         = ST_IDLE;
                end
            end

            ST_DEC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rb_rd_data & bin_mask;
                addr_next  = rb_rd_data & bin_mask;
                state_next = ST_DEC_WR;
            end

            ST_DEC_WR:
            begin
                // Saturated and empty counters stay as they are.
                if ((ram_rdata != '0) && (ram_rdata != scsf_pkg::SAT_MAX))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata - COUNT_W'(1);
                end
                idx_next  = idx_inc;
                rb_rd_idx = idx_inc[IDX_W-1:0];
                if (idx_inc == rb_fill)
                begin
                    done_next          = 1'b1;
                    verdict_valid_next = 1'b1;
                    singleton_next     = 1'b1;
                    tally_next         = '0;
                    overflow_next      = rb_status.overflow_seen;
                    rb_ctrl.restart    = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DEC_RD;
                end
            end

            ST_CEN_RD:
            begin
                ram_re      = 1'b1;
                rvalid_next = 1'b1;
                census_next = census_reg + TALLY_W'(cen_inc);
                if (addr_reg == bin_mask)
                begin
                    state_next = ST_CEN_TAIL;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            ST_CEN_TAIL:
            begin
                census_next        = census_reg + TALLY_W'(cen_inc);
                done_next          = 1'b1;
                verdict_valid_next = 1'b0;
                singleton_next     = 1'b0;
                tally_next         = census_next;
                overflow_next      = 1'b0;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            addr_reg          <= '0;
            has_reg           <= 1'b0;
            last_reg          <= 1'b0;
            idx_reg           <= '0;
            filled_reg        <= '0;
            census_reg        <= '0;
            rvalid_reg        <= 1'b0;
            lg_reg            <= scsf_pkg::LOG2_BINS_IN_USE_RESET;
            done_reg          <= 1'b0;
            verdict_valid_reg <= 1'b0;
            singleton_reg     <= 1'b0;
            tally_reg         <= '0;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            addr_reg          <= addr_next;
            has_reg           <= has_next;
            last_reg          <= last_next;
            idx_reg           <= idx_next;
            filled_reg        <= filled_next;
            census_reg        <= census_next;
            rvalid_reg        <= rvalid_next;
            lg_reg            <= lg_next;
            done_reg          <= done_next;
            verdict_valid_reg <= verdict_valid_next;
            singleton_reg     <= singleton_next;
            tally_reg         <= tally_next;
            overflow_reg      <= overflow_next;
        end
    end

    scsf_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scsf_relbuf #(
        .MAX_IDEALS (MAX_IDEALS),
        .DATA_W     (ADDR_W)
    ) u_relbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rb_ctrl),
        .push_data (in_bin),
        .rd_idx    (rb_rd_idx),
        .rd_data   (rb_rd_data),
        .fill      (rb_fill),
        .status    (rb_status)
    );

    assign done          = done_reg;
    assign verdict_valid = verdict_valid_reg;
    assign singleton     = singleton_reg;
    assign tally         = tally_reg;
    assign overflow      = overflow_reg;

endmodule

>>> rtl/scsf_ram.sv
// ============================================================================
// scsf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
`timescale 1ns / 1ps

module scsf_ram #(
    parameter int ADDR_W = scsf_pkg::LOG2_BINS_DEFAULT,
    parameter int DATA_W = scsf_pkg::COUNT_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/scsf_relbuf.sv
// ============================================================================
// scsf_relbuf
// Bin buffer of one relation with fill count and singleton/overflow flags.
// ============================================================================
`timescale 1ns / 1ps

module scsf_relbuf #(
    parameter int MAX_IDEALS = scsf_pkg::MAX_IDEALS_DEFAULT,
    parameter int DATA_W     = scsf_pkg::LOG2_BINS_DEFAULT,
    localparam int IDX_W     = $clog2(MAX_IDEALS),
    localparam int FILL_W    = $clog2(MAX_IDEALS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scsf_pkg::rb_ctrl_t   ctrl,
    input  logic [DATA_W-1:0]    push_data,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic [DATA_W-1:0]    rd_data,
    output logic [FILL_W-1:0]    fill,
    output scsf_pkg::rb_status_t status
);

    logic [DATA_W-1:0]    mem [MAX_IDEALS];
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    scsf_pkg::rb_status_t status_reg;
    scsf_pkg::rb_status_t status_next;
    logic                 has_room;

    assign has_room = fill_reg < FILL_W'(MAX_IDEALS);

    always_comb
    begin
        fill_next   = fill_reg;
        status_next = status_reg;
        if (ctrl.restart)
        begin
            fill_next   = '0;
            status_next = '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                if (has_room)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                else
                begin
                    status_next.overflow_seen = 1'b1;
                end
            end
            if (ctrl.mark_singleton)
            begin
                status_next.singleton_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            status_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            status_reg <= status_next;
        end
    end

    // Bin storage: written at the fill point, read back through a register.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && has_room && !ctrl.restart)
        begin
            mem[fill_reg[IDX_W-1:0]] <= push_data;
        end
        rd_data <= mem[rd_idx];
    end

    assign fill   = fill_reg;
    assign status = status_reg;

endmodule

>>> rtl/scsf_checker.sv
// ============================================================================
// scsf_checker
// Port-level checks of the saturating count singleton filter.
// ============================================================================
`timescale 1ns / 1ps
`include "saturating_count_singleton_filter_macros.svh"

module scsf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         verdict_valid,
    input logic                         singleton,
    input logic [scsf_pkg::TALLY_W-1:0] tally,
    input logic                         overflow
);

    // Every accepted command keeps the block busy in the following cycle.
    `SCSF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // A result appears as the block returns to idle, and never twice in a row.
    `SCSF_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `SCSF_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // Verdict fields and tally never share a result, and the flags need a verdict.
    `SCSF_ASSERT_IMPL(a_verdict_no_tally, clk, rst_n, done && verdict_valid, tally == '0)
    `SCSF_ASSERT_IMPL(a_flags_need_verdict, clk, rst_n, done && !verdict_valid,
        !singleton && !overflow)

endmodule

bind saturating_count_singleton_filter scsf_checker u_scsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .verdict_valid (verdict_valid),
    .singleton     (singleton),
    .tally         (tally),
    .overflow      (overflow)
);
